### src/idepio_pkg.sv
// Shared types and constants for the IDE PIO task-file controller.
package idepio_pkg;

    // Task-file status and command codes
    localparam logic [7:0] ST_READY     = 8'h40;
    localparam logic [7:0] CMD_READ     = 8'h20;
    localparam logic [7:0] CMD_WRITE    = 8'h30;
    localparam logic [7:0] CMD_DMA_READ = 8'hC8;
    localparam logic [7:0] LBA_TOP_MASK = 8'h1F;

    // Request types
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Disk operation codes
    localparam logic [1:0] DOP_NONE  = 2'd0;
    localparam logic [1:0] DOP_READ  = 2'd1;
    localparam logic [1:0] DOP_WRITE = 2'd2;

    localparam logic [2:0] PORT_DATA = 3'd0;
    localparam logic [2:0] PORT_CMD  = 3'd7;
    localparam logic [2:0] SIZE_WORD = 3'd4;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        req_type;
        logic [2:0]  port;
        logic [2:0]  size;
        logic [31:0] wdata;
        logic [31:0] disk_rdata;
    } t_in_item;

    typedef struct packed {
        logic [31:0] rdata;
        logic [1:0]  disk_op;
        logic [31:0] disk_wdata;
        logic [31:0] disk_pos;
        logic        irq;
        logic        error;
    } t_out_item;

    // Classified access, as handed from the front to the back
    typedef struct packed {
        logic        wr_access;
        logic        data_xfer;
        logic        cmd_port;
        logic [2:0]  port;
        logic [7:0]  wr_en;
        logic [63:0] wr_bytes;
        logic [3:0]  rd_en;
        logic [31:0] disk_rdata;
    } t_cmd;

endpackage

### src/idepio_front.sv
// Front end: decodes one bus access into port byte enables and aligned data.
module idepio_front (
    input  idepio_pkg::t_in_item i_item,
    output idepio_pkg::t_cmd     o_cmd
);

    logic [2:0] w_len;

    always_comb begin
        logic [3:0] p;
        w_len = (i_item.size > idepio_pkg::SIZE_WORD) ? idepio_pkg::SIZE_WORD : i_item.size;

        o_cmd            = '0;
        o_cmd.wr_access  = (i_item.req_type == idepio_pkg::REQ_WRITE);
        o_cmd.port       = i_item.port;
        o_cmd.data_xfer  = (i_item.port == idepio_pkg::PORT_DATA) &&
                           (i_item.size == idepio_pkg::SIZE_WORD);
        o_cmd.cmd_port   = (i_item.req_type == idepio_pkg::REQ_WRITE) &&
                           (i_item.port == idepio_pkg::PORT_CMD);
        o_cmd.disk_rdata = i_item.disk_rdata;

        // bytes past the last port are dropped on write, read as zero
        for (int i = 0; i < 4; i++) begin
            p = {1'b0, i_item.port} + 4'(i);
            if ((3'(i) < w_len) && !p[3]) begin
                o_cmd.rd_en[i] = 1'b1;
                if (i_item.req_type == idepio_pkg::REQ_WRITE) begin
                    o_cmd.wr_en[p[2:0]]            = 1'b1;
                    o_cmd.wr_bytes[p[2:0]*8 +: 8]  = i_item.wdata[i*8 +: 8];
                end
            end
        end
    end

endmodule

### src/idepio_queue.sv
// Short FIFO of classified accesses between front and back.
module idepio_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  idepio_pkg::t_cmd i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output idepio_pkg::t_cmd o_head
);

    idepio_pkg::t_cmd                    r_mem [idepio_pkg::QUEUE_DEPTH];
    logic [idepio_pkg::QPTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [idepio_pkg::QPTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [idepio_pkg::QCNT_W-1:0]       r_cnt,    n_cnt;

    localparam logic [idepio_pkg::QPTR_W-1:0] LAST_PTR =
        idepio_pkg::QPTR_W'(idepio_pkg::QUEUE_DEPTH - 1);
    localparam logic [idepio_pkg::QCNT_W-1:0] FULL_CNT =
        idepio_pkg::QCNT_W'(idepio_pkg::QUEUE_DEPTH);

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### src/idepio_back.sv
// Back end: task-file state, command execution and the result register.
module idepio_back #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  idepio_pkg::t_cmd      i_cmd,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output idepio_pkg::t_out_item o_out_item
);

    localparam int CNT_W = $clog2(SECTOR_BYTES + 4);
    localparam logic [CNT_W-1:0] SB_CNT = CNT_W'(SECTOR_BYTES);
    localparam logic [CNT_W-1:0] WORD_CNT = CNT_W'(4);
    localparam logic [31:0] SB32 = 32'(SECTOR_BYTES);
    localparam logic [63:0] PORTS_RST = {idepio_pkg::ST_READY, 56'h0};

    logic [63:0]           r_ports, n_ports;
    logic [CNT_W-1:0]      r_cnt,   n_cnt;
    logic                  r_wmode, n_wmode;
    logic [31:0]           r_pos,   n_pos;
    logic                  r_out_valid;
    idepio_pkg::t_out_item r_out,   n_out;

    logic [CNT_W-1:0] w_cnt_next;
    logic             w_cnt_full;
    logic [7:0]       w_cmd;
    logic [28:0]      w_sector;
    logic [63:0]      w_shifted;

    assign o_pop       = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_cnt_next = r_cnt + WORD_CNT;
    assign w_cnt_full = (r_cnt >= SB_CNT);

    always_comb begin
        n_ports = r_ports;
        for (int j = 0; j < 8; j++) begin
            if (i_cmd.wr_en[j]) begin
                n_ports[j*8 +: 8] = i_cmd.wr_bytes[j*8 +: 8];
            end
        end
        w_cmd    = n_ports[63:56];
        w_sector = {5'(n_ports[55:48] & idepio_pkg::LBA_TOP_MASK), n_ports[47:24]};

        n_cnt   = r_cnt;
        n_wmode = r_wmode;
        n_pos   = r_pos;
        n_out   = '0;
        n_out.disk_op = idepio_pkg::DOP_NONE;

        if (i_cmd.wr_access) begin
            if (i_cmd.data_xfer) begin
                if (!r_wmode || w_cnt_full) begin
                    n_out.error = 1'b1;
                end else begin
                    n_out.disk_op    = idepio_pkg::DOP_WRITE;
                    n_out.disk_wdata = n_ports[31:0];
                    n_cnt            = w_cnt_next;
                    n_pos            = r_pos + 32'd4;
                    if (w_cnt_next >= SB_CNT) begin
                        n_ports[63:56] = idepio_pkg::ST_READY;
                    end
                end
            end else if (i_cmd.cmd_port) begin
                if (w_cmd == idepio_pkg::CMD_READ || w_cmd == idepio_pkg::CMD_WRITE) begin
                    n_pos = 32'({3'b000, w_sector} * SB32);
                    n_cnt = '0;
                    if (w_cmd == idepio_pkg::CMD_READ) begin
                        n_wmode        = 1'b0;
                        n_ports[63:56] = idepio_pkg::ST_READY;
                        n_out.irq      = 1'b1;
                    end else begin
                        n_wmode = 1'b1;
                    end
                end else if (w_cmd != idepio_pkg::CMD_DMA_READ) begin
                    n_out.error = 1'b1;
                end
            end
        end else if (i_cmd.data_xfer) begin
            if (r_wmode || w_cnt_full) begin
                n_out.error = 1'b1;
            end else begin
                n_out.disk_op  = idepio_pkg::DOP_READ;
                n_ports[31:0]  = i_cmd.disk_rdata;
                n_cnt          = w_cnt_next;
                n_pos          = r_pos + 32'd4;
                if (w_cnt_next >= SB_CNT) begin
                    n_ports[63:56] = idepio_pkg::ST_READY;
                end
            end
        end

        // read back the accessed ports after handling
        w_shifted = n_ports >> {i_cmd.port, 3'b000};
        for (int i = 0; i < 4; i++) begin
            n_out.rdata[i*8 +: 8] = i_cmd.rd_en[i] ? w_shifted[i*8 +: 8] : 8'h00;
        end
        n_out.disk_pos = n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ports     <= PORTS_RST;
            r_cnt       <= '0;
            r_wmode     <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_ports <= n_ports;
                r_cnt   <= n_cnt;
                r_wmode <= n_wmode;
                r_pos   <= n_pos;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[1:0] == 2'b00)
        else $error("transfer count not word aligned");

    a_op_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.error && (r_out.disk_op != idepio_pkg::DOP_NONE)))
        else $error("disk transfer flagged as error");

    a_irq_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.irq) |->
            (r_out.disk_op == idepio_pkg::DOP_NONE && !r_out.error))
        else $error("interrupt with disk transfer or error");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && n_out.disk_op != idepio_pkg::DOP_NONE) |=>
            (r_pos == $past(r_pos) + 32'd4) && (r_out.disk_pos == r_pos))
        else $error("disk position did not advance by one word");
`endif

endmodule

### src/ide_pio_disk_controller.sv
// Top level of the IDE PIO task-file controller with 29-bit LBA sector addressing.
//
//  channel   direction  handshake                 payload
//  in        slave      i_in_valid / o_in_ready   i_in_item  (t_in_item)
//  out       master     o_out_valid / i_out_ready o_out_item (t_out_item)
//
// One bus access per cycle sustained while the output is not stalled. An
// accepted access sits in the two-entry queue and its result is registered
// in the output register once that register is free or being taken.
// The back end updates the task-file state once per access, as it is popped.
// A stalled output fills the queue; o_in_ready falls only when it is full.
// Synchronous active-low reset restores the status byte to ready, clears
// the rest of the task file, count, direction and disk position.
module ide_pio_disk_controller #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  idepio_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output idepio_pkg::t_out_item o_out_item
);

    idepio_pkg::t_cmd w_cmd;      // classified incoming transfer
    idepio_pkg::t_cmd w_head;     // oldest queued transfer
    logic             w_full;
    logic             w_q_valid;
    logic             w_pop;
    logic             w_push;

    // nothing in the front depends on task-file state, so decode is free to
    // run ahead of the back end
    idepio_front u_front (
        .i_item (i_in_item),
        .o_cmd  (w_cmd)
    );

    assign o_in_ready = !w_full;
    assign w_push     = i_in_valid && !w_full;

    idepio_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    // back end owns the port bytes, count, direction and disk position
    idepio_back #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_cmd       (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
